>>> rtl/core/ovn_pkg.sv
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared constants for the octave value noise pipeline: coordinate width,
// per-octave stage count and the integer hash constants.
// ----------------------------------------------------------------------------
package ovn_pkg;

   localparam int COORD_W = 8;

   // register stages inside one octave lane: four hash, one x blend,
   // two y blend, two z blend
   localparam int OCT_STAGES = 9;

   localparam logic [31:0] HASH_MUL_Y = 32'd57;
   localparam logic [31:0] HASH_MUL_Z = 32'd23;
   localparam int          HASH_SHIFT = 13;
   localparam logic [31:0] HASH_MUL_SQ = 32'd15731;
   localparam logic [31:0] HASH_ADD_T = 32'd789221;
   localparam logic [31:0] HASH_ADD_M = 32'd1376312589;
   localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
   localparam logic [32:0] HASH_ONE = 33'h0_8000_0000;

endpackage

>>> rtl/core/ovn_hash.sv
// ----------------------------------------------------------------------------
// ovn_hash
// Four-stage integer hash of one lattice corner; returns the corner value
// in units of 2^-31 (1 .. 2^31).
// ----------------------------------------------------------------------------
module ovn_hash import ovn_pkg::*; (
   input  logic               clock,
   input  logic [3:0]         stage_en,
   input  logic [31:0]        corner_x,
   input  logic [31:0]        corner_y,
   input  logic [31:0]        corner_z,
   output logic signed [32:0] value
);

   logic [31:0]        sum_w;
   logic [31:0]        n_in;
   logic [31:0]        n_ff [3];
   logic [31:0]        sq_ff;
   logic [31:0]        t_ff;
   logic [31:0]        m_w;
   logic signed [32:0] value_ff;

   always_comb begin
      sum_w = corner_x + corner_y * HASH_MUL_Y + corner_z * HASH_MUL_Z;
      n_in  = (sum_w << HASH_SHIFT) ^ sum_w;
      m_w   = (n_ff[2] * t_ff + HASH_ADD_M) & HASH_MASK;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         n_ff[0] <= n_in;
      end
      if (stage_en[1]) begin
         n_ff[1] <= n_ff[0];
         sq_ff   <= n_ff[0] * n_ff[0];
      end
      if (stage_en[2]) begin
         n_ff[2] <= n_ff[1];
         t_ff    <= sq_ff * HASH_MUL_SQ + HASH_ADD_T;
      end
      if (stage_en[3]) begin
         value_ff <= $signed(HASH_ONE - {1'b0, m_w});
      end
   end

   assign value = value_ff;

endmodule

>>> rtl/core/ovn_lerp.sv
// ----------------------------------------------------------------------------
// ovn_lerp
// Two-stage exact blend q = a*2^SH + (b-a)*f. The difference is split at
// bit 32 so each multiplier stays narrow; the partials join in stage two.
// ----------------------------------------------------------------------------
module ovn_lerp import ovn_pkg::*; #(
   parameter int AW = 34,
   parameter int OW = 35,
   parameter int FW = 2,
   parameter int SH = 1
) (
   input  logic                 clock,
   input  logic [1:0]           stage_en,
   input  logic signed [AW-1:0] a,
   input  logic signed [AW-1:0] b,
   input  logic [FW-1:0]        f,
   output logic signed [OW-1:0] q
);

   localparam int DFW = AW + 1;
   localparam int HW  = DFW - 32;
   localparam int LPW = 32 + FW;
   localparam int HPW = HW + FW + 1;

   logic signed [DFW-1:0] diff_w;
   logic [31:0]           dlo_w;
   logic signed [HW-1:0]  dhi_w;
   logic signed [FW:0]    fs_w;
   logic [LPW-1:0]        plo_in;
   logic signed [HPW-1:0] phi_in;
   logic [LPW-1:0]        plo_ff;
   logic signed [HPW-1:0] phi_ff;
   logic signed [AW-1:0]  a_ff;
   logic signed [OW-1:0]  base_w;
   logic signed [OW-1:0]  hi_w;
   logic signed [OW-1:0]  lo_w;
   logic signed [OW-1:0]  q_ff;

   always_comb begin
      diff_w = DFW'(b) - DFW'(a);
      dlo_w  = diff_w[31:0];
      dhi_w  = diff_w[DFW-1:32];
      fs_w   = $signed({1'b0, f});
      plo_in = LPW'(dlo_w) * LPW'(f);
      phi_in = HPW'(dhi_w) * HPW'(fs_w);
      base_w = OW'(a_ff);
      hi_w   = OW'(phi_ff);
      lo_w   = $signed(OW'(plo_ff));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_ff   <= a;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (stage_en[1]) begin
         q_ff <= (base_w <<< SH) + (hi_w <<< 32) + lo_w;
      end
   end

   assign q = q_ff;

endmodule

>>> rtl/core/ovn_octave.sv
// ----------------------------------------------------------------------------
// ovn_octave
// One octave lane: eight corner hashes, then trilinear blend along x, y, z.
// Output is the blend in units of 2^-(31+3*CELL_LOG2).
// ----------------------------------------------------------------------------
module ovn_octave import ovn_pkg::*; #(
   parameter int SPACE_LOG2 = 8,
   parameter int CELL_LOG2  = 8
) (
   input  logic                            clock,
   input  logic [OCT_STAGES-1:0]           stage_en,
   input  logic [COORD_W-1:0]              coord_x,
   input  logic [COORD_W-1:0]              coord_y,
   input  logic [COORD_W-1:0]              coord_z,
   output logic signed [33+3*SPACE_LOG2-1:0] blend
);

   localparam int FW = SPACE_LOG2 + 1;
   localparam int BW = 33 + SPACE_LOG2;
   localparam int CW = 33 + 2 * SPACE_LOG2;
   localparam int DW = 33 + 3 * SPACE_LOG2;
   localparam int PXW = 34 + FW;
   localparam logic [31:0] CELL = 32'(1) << CELL_LOG2;
   localparam logic [31:0] FMASK = CELL - 32'd1;
   localparam logic [31:0] WMASK = (32'(1) << SPACE_LOG2) - 32'd1;

   logic [31:0]          px_w, py_w, pz_w;
   logic [31:0]          lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
   logic [3*FW-1:0]      frac_in;
   logic [3*FW-1:0]      frac_ff [7];
   logic signed [32:0]   corner_v [8];
   logic signed [BW-1:0] b_ff [4];
   logic signed [CW-1:0] c_w [2];
   logic [FW-1:0]        fx_w;

   always_comb begin
      px_w = 32'(coord_x);
      py_w = 32'(coord_y);
      pz_w = 32'(coord_z);
      lo_x = px_w & ~FMASK;
      lo_y = py_w & ~FMASK;
      lo_z = pz_w & ~FMASK;
      hi_x = (lo_x + CELL) & WMASK;
      hi_y = (lo_y + CELL) & WMASK;
      hi_z = (lo_z + CELL) & WMASK;
      frac_in = {FW'(pz_w & FMASK), FW'(py_w & FMASK), FW'(px_w & FMASK)};
      fx_w = frac_ff[3][FW-1:0];
   end

   // corner index: bit 0 picks upper x, bit 1 upper y, bit 2 upper z
   for (genvar c = 0; c < 8; c++) begin : g_corner
      ovn_hash u_hash (
         .clock    (clock),
         .stage_en (stage_en[3:0]),
         .corner_x (((c & 1) != 0) ? hi_x : lo_x),
         .corner_y (((c & 2) != 0) ? hi_y : lo_y),
         .corner_z (((c & 4) != 0) ? hi_z : lo_z),
         .value    (corner_v[c])
      );
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         frac_ff[0] <= frac_in;
      end
      for (int i = 1; i < 7; i++) begin
         if (stage_en[i]) begin
            frac_ff[i] <= frac_ff[i-1];
         end
      end
   end

   // x blend: one stage, pairs of corners share y and z
   for (genvar j = 0; j < 4; j++) begin : g_xblend
      logic signed [33:0]    dx_w;
      logic signed [PXW-1:0] px_prod_w;
      logic signed [BW-1:0]  base_w;

      always_comb begin
         dx_w      = 34'(corner_v[2*j+1]) - 34'(corner_v[2*j]);
         px_prod_w = PXW'(dx_w) * PXW'($signed({1'b0, fx_w}));
         base_w    = BW'(corner_v[2*j]);
      end

      always_ff @(posedge clock) begin
         if (stage_en[4]) begin
            b_ff[j] <= (base_w <<< CELL_LOG2) + BW'(px_prod_w);
         end
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_yblend
      ovn_lerp #(.AW(BW), .OW(CW), .FW(FW), .SH(CELL_LOG2)) u_lerp (
         .clock    (clock),
         .stage_en (stage_en[6:5]),
         .a        (b_ff[2*j]),
         .b        (b_ff[2*j+1]),
         .f        (frac_ff[4][2*FW-1:FW]),
         .q        (c_w[j])
      );
   end

   ovn_lerp #(.AW(CW), .OW(DW), .FW(FW), .SH(CELL_LOG2)) u_zblend (
      .clock    (clock),
      .stage_en (stage_en[8:7]),
      .a        (c_w[0]),
      .b        (c_w[1]),
      .f        (frac_ff[6][3*FW-1:2*FW]),
      .q        (blend)
   );

endmodule

>>> rtl/core/octave_value_noise_3d_top.sv
// ----------------------------------------------------------------------------
// octave_value_noise_3d_top
// Multi-octave 3D value noise: one lattice point in, one Q2.30 sum out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a lattice point (coord_x, coord_y, coord_z); a
//   transfer happens on a clock edge with req_valid high and req_stall low.
//   rsp channel returns one rsp_noise_sum per request, in request order,
//   as signed Q2.30 (always in (0,2)).
//   Eleven register stages: the request's valid bit enters the first stage
//   on the transfer edge, and rsp_valid is the valid bit of the last stage.
//   Throughput is one point per cycle while rsp_stall is low: every
//   octave has its own hash and blend lane.
//   Stages: 4 hash (five multiplies), 1 x blend, 2 y blend, 2 z blend,
//   1 octave group add, 1 final add into the output register.
//   Each stage carries a valid bit and loads only when it is empty or the
//   stage after it moves, so a stalled rsp side backs up stage by stage
//   and bubbles are squeezed out; nothing is dropped or repeated.
//   req_stall rises only once every stage holds a transfer.
//   Reset (synchronous) clears all valid bits; data registers are left.
// ----------------------------------------------------------------------------
module octave_value_noise_3d_top import ovn_pkg::*; #(
   parameter int SPACE_WIDTH  = 256,
   parameter int OCTAVE_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic [COORD_W-1:0]  req_coord_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_noise_sum
);

   localparam int K     = $clog2(SPACE_WIDTH);
   localparam int DW    = 33 + 3 * K;
   localparam int FBITS = 30 + 3 * K + OCTAVE_COUNT;   // total in 2^-FBITS
   localparam int RSH   = FBITS - 30;
   localparam int TW    = FBITS + 2;
   localparam int NG    = (OCTAVE_COUNT + 2) / 3;       // groups of three
   localparam int NS    = OCT_STAGES + 2;

   logic [NS:0]    stage_en;
   logic [NS-1:0]  vld_ff;
   logic [DW-1:0]  oct_d [OCTAVE_COUNT];
   logic [TW-1:0]  grp_in [NG];
   logic [TW-1:0]  grp_ff [NG];
   logic [TW-1:0]  total_w;
   logic [31:0]    sum_ff;

   // a stage may load when it is empty or its successor loads
   always_comb begin
      stage_en[NS] = !rsp_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i+1];
      end
   end

   assign req_stall = !stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // octave o uses cell size 2^(K-o), floored at one lattice step
   for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_octave
      ovn_octave #(
         .SPACE_LOG2 (K),
         .CELL_LOG2  ((K > o) ? K - o : 0)
      ) u_octave (
         .clock    (clock),
         .stage_en (stage_en[OCT_STAGES-1:0]),
         .coord_x  (req_coord_x),
         .coord_y  (req_coord_y),
         .coord_z  (req_coord_z),
         .blend    (oct_d[o])
      );
   end

   // align each octave to 2^-FBITS (includes the 2^-o weight), then add
   // in groups of three
   always_comb begin
      int ko;
      int sh;
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
      end
      for (int o = 0; o < OCTAVE_COUNT; o++) begin
         ko = (K > o) ? K - o : 0;
         sh = FBITS - 31 - 3 * ko - o;
         grp_in[o/3] = grp_in[o/3] + (TW'(oct_d[o]) << sh);
      end
      total_w = '0;
      for (int g = 0; g < NG; g++) begin
         total_w = total_w + grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NS-2]) begin
         grp_ff <= grp_in;
      end
      if (stage_en[NS-1]) begin
         sum_ff <= total_w[TW-1:RSH];   // floor to 2^-30
      end
   end

   assign rsp_valid     = vld_ff[NS-1];
   assign rsp_noise_sum = $signed(sum_ff);

endmodule
